@@ design/c86x_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package c86x_pkg;

  // opcodes
  localparam logic [7:0] OP_JCC_LO   = 8'h60;
  localparam logic [7:0] OP_JCC_HI   = 8'h7F;
  localparam logic [7:0] OP_MOV_R8_LO = 8'hB0;
  localparam logic [7:0] OP_MOV_R8_HI = 8'hB7;
  localparam logic [7:0] OP_SAHF     = 8'h9E;
  localparam logic [7:0] OP_LAHF     = 8'h9F;
  localparam logic [7:0] OP_JMP_FAR  = 8'hEA;
  localparam logic [7:0] OP_CLC      = 8'hF8;
  localparam logic [7:0] OP_STC      = 8'hF9;
  localparam logic [7:0] OP_CLI      = 8'hFA;
  localparam logic [7:0] OP_STI      = 8'hFB;
  localparam logic [7:0] OP_CLD      = 8'hFC;
  localparam logic [7:0] OP_STD      = 8'hFD;

  // flag bit positions
  localparam int unsigned FLAG_CF = 0;
  localparam int unsigned FLAG_PF = 2;
  localparam int unsigned FLAG_ZF = 6;
  localparam int unsigned FLAG_SF = 7;
  localparam int unsigned FLAG_IF = 9;
  localparam int unsigned FLAG_DF = 10;
  localparam int unsigned FLAG_OF = 11;

  localparam logic [15:0] SAHF_KEEP_MASK = 16'hFF2A;
  localparam logic [7:0]  SAHF_LOAD_MASK = 8'hD5;
  localparam logic [7:0]  LAHF_KEEP_MASK = 8'h2A;
  localparam logic [7:0]  LAHF_LOAD_MASK = 8'hD7;

  localparam logic [15:0] FLAGS_RESET = 16'hF002;
  localparam logic [15:0] CS_RESET    = 16'hFFFF;

  // general register file index
  localparam logic [1:0] GPR_AX = 2'd0;
  localparam logic [1:0] GPR_CX = 2'd1;
  localparam logic [1:0] GPR_DX = 2'd2;
  localparam logic [1:0] GPR_BX = 2'd3;

  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_SHORT = 3'd2;
  localparam logic [2:0] LEN_FAR   = 3'd5;

  typedef enum logic [2:0] {
    JCC_O,
    JCC_C,
    JCC_Z,
    JCC_BE,
    JCC_S,
    JCC_P,
    JCC_L,
    JCC_LE
  } jcc_t;

  typedef struct packed {
    logic [15:0]      ip;
    logic [15:0]      cs;
    logic [15:0]      flags;
    logic [3:0][15:0] gpr;
  } arch_state_t;

  typedef struct packed {
    logic [2:0] len;
    logic       unknown;
  } exec_status_t;

endpackage

`default_nettype wire

@@ design/c86x_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none

module c86x_exec (
  input  wire logic [7:0]          cmd,
  input  wire logic [15:0]         operand_word,
  input  wire logic [15:0]         segment_word,
  input  wire c86x_pkg::arch_state_t st,
  output c86x_pkg::arch_state_t    st_next,
  output c86x_pkg::exec_status_t   status
);

  logic        cf, pf, zf, sf, of_flag;
  logic        cond;
  logic        taken;
  logic [15:0] rel;
  logic [7:0]  ah;
  c86x_pkg::jcc_t jcc;

  assign cf      = st.flags[c86x_pkg::FLAG_CF];
  assign pf      = st.flags[c86x_pkg::FLAG_PF];
  assign zf      = st.flags[c86x_pkg::FLAG_ZF];
  assign sf      = st.flags[c86x_pkg::FLAG_SF];
  assign of_flag = st.flags[c86x_pkg::FLAG_OF];
  assign jcc     = c86x_pkg::jcc_t'(cmd[3:1]);
  assign rel     = {{8{operand_word[7]}}, operand_word[7:0]};
  assign ah      = st.gpr[c86x_pkg::GPR_AX][15:8];

  always_comb begin
    unique case (jcc)
      c86x_pkg::JCC_O:  cond = of_flag;
      c86x_pkg::JCC_C:  cond = cf;
      c86x_pkg::JCC_Z:  cond = zf;
      c86x_pkg::JCC_BE: cond = cf | zf;
      c86x_pkg::JCC_S:  cond = sf;
      c86x_pkg::JCC_P:  cond = pf;
      c86x_pkg::JCC_L:  cond = sf ^ of_flag;
      c86x_pkg::JCC_LE: cond = (sf ^ of_flag) | zf;
      default:          cond = 1'b0;
    endcase
    // odd opcodes test the inverse
    taken = cmd[0] ? ~cond : cond;
  end

  always_comb begin
    st_next        = st;
    status.len     = c86x_pkg::LEN_ONE;
    status.unknown = 1'b0;
    priority if (cmd >= c86x_pkg::OP_JCC_LO && cmd <= c86x_pkg::OP_JCC_HI) begin
      st_next.ip = taken ? st.ip + 16'd2 + rel : st.ip + 16'd2;
      status.len = c86x_pkg::LEN_SHORT;
    end else if (cmd >= c86x_pkg::OP_MOV_R8_LO && cmd <= c86x_pkg::OP_MOV_R8_HI) begin
      if (cmd[2]) begin
        st_next.gpr[cmd[1:0]][15:8] = operand_word[7:0];
      end else begin
        st_next.gpr[cmd[1:0]][7:0] = operand_word[7:0];
      end
      st_next.ip = st.ip + 16'd2;
      status.len = c86x_pkg::LEN_SHORT;
    end else begin
      st_next.ip = st.ip + 16'd1;
      unique case (cmd)
        c86x_pkg::OP_SAHF: begin
          st_next.flags = (st.flags & c86x_pkg::SAHF_KEEP_MASK)
                        | {8'h00, ah & c86x_pkg::SAHF_LOAD_MASK};
        end
        c86x_pkg::OP_LAHF: begin
          st_next.gpr[c86x_pkg::GPR_AX][15:8] = (ah & c86x_pkg::LAHF_KEEP_MASK)
                                           | (st.flags[7:0] & c86x_pkg::LAHF_LOAD_MASK);
        end
        c86x_pkg::OP_JMP_FAR: begin
          st_next.ip = operand_word;
          st_next.cs = segment_word;
          status.len = c86x_pkg::LEN_FAR;
        end
        c86x_pkg::OP_CLC: st_next.flags[c86x_pkg::FLAG_CF] = 1'b0;
        c86x_pkg::OP_STC: st_next.flags[c86x_pkg::FLAG_CF] = 1'b1;
        c86x_pkg::OP_CLI: st_next.flags[c86x_pkg::FLAG_IF] = 1'b0;
        c86x_pkg::OP_STI: st_next.flags[c86x_pkg::FLAG_IF] = 1'b1;
        c86x_pkg::OP_CLD: st_next.flags[c86x_pkg::FLAG_DF] = 1'b0;
        c86x_pkg::OP_STD: st_next.flags[c86x_pkg::FLAG_DF] = 1'b1;
        default: status.unknown = 1'b1;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/cpu8086_subset_executor.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Executes one 8086 instruction per request: short conditional jumps, SAHF, LAHF,
// MOV r8,imm8, JMP FAR and the CLC/STC/CLI/STI/CLD/STD flag ops; anything else is
// a one-byte no-op flagged as unknown. Each request is decoded and executed against
// the architectural registers in the cycle it is accepted, and the updated registers
// are the result seen on the output ports from the next cycle. A new request is
// taken every cycle while the result side keeps up, since the register state after
// one instruction is the only input the next one needs.
module cpu8086_subset_executor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  cmd,
  input  wire logic [15:0] operand_word,
  input  wire logic [15:0] segment_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      next_ip,
  output logic [15:0]      code_segment,
  output logic [15:0]      flags_word,
  output logic [15:0]      reg_ax,
  output logic [15:0]      reg_bx,
  output logic [15:0]      reg_cx,
  output logic [15:0]      reg_dx,
  output logic [2:0]       bytes_used,
  output logic             unknown_opcode
);

  c86x_pkg::arch_state_t  st;
  c86x_pkg::arch_state_t  st_next;
  c86x_pkg::exec_status_t status;
  c86x_pkg::exec_status_t status_q;
  logic                   in_fire;

  // state only advances when the previous result is gone or leaving
  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;

  c86x_exec u_exec (
    .cmd          (cmd),
    .operand_word (operand_word),
    .segment_word (segment_word),
    .st           (st),
    .st_next      (st_next),
    .status       (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.ip     <= 16'h0000;
      st.cs     <= c86x_pkg::CS_RESET;
      st.flags  <= c86x_pkg::FLAGS_RESET;
      st.gpr    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_q <= status;
    end
  end

  assign next_ip        = st.ip;
  assign code_segment   = st.cs;
  assign flags_word     = st.flags;
  assign reg_ax         = st.gpr[c86x_pkg::GPR_AX];
  assign reg_bx         = st.gpr[c86x_pkg::GPR_BX];
  assign reg_cx         = st.gpr[c86x_pkg::GPR_CX];
  assign reg_dx         = st.gpr[c86x_pkg::GPR_DX];
  assign bytes_used     = status_q.len;
  assign unknown_opcode = status_q.unknown;

  a_len_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bytes_used == c86x_pkg::LEN_ONE || bytes_used == c86x_pkg::LEN_SHORT
                   || bytes_used == c86x_pkg::LEN_FAR))
    else $error("bytes_used outside 1, 2, 5");

  a_unknown_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && unknown_opcode) |-> bytes_used == c86x_pkg::LEN_ONE)
    else $error("unknown opcode with length other than one");

  a_far_jump: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd == c86x_pkg::OP_JMP_FAR)
      |=> (code_segment == $past(segment_word) && next_ip == $past(operand_word)))
    else $error("far jump did not load cs:ip");

  a_unknown_keeps: assert property (@(posedge clk) disable iff (rst)
    (in_fire && status.unknown)
      |=> ($stable(flags_word) && $stable(code_segment) && $stable(reg_ax)
           && next_ip == $past(next_ip) + 16'd1))
    else $error("unknown opcode changed state");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("stalled with empty output");

endmodule

`default_nettype wire

@@ sim/cpu8086_subset_executor_test.sv @@
`timescale 1ns / 1ps

typedef struct {
  logic [15:0] ip;
  logic [15:0] cs;
  logic [15:0] flags;
  logic [15:0] ax;
  logic [15:0] bx;
  logic [15:0] cx;
  logic [15:0] dx;
  logic [2:0]  len;
  logic        unknown;
} retire_rec_t;

class exec_scoreboard;
  logic [15:0] gpr [4];
  logic [15:0] flags;
  logic [15:0] cs;
  logic [15:0] ip;
  retire_rec_t retire_q[$];
  int unsigned mismatches;

  function new();
    for (int i = 0; i < 4; i++) gpr[i] = 16'h0000;
    flags = c86x_pkg::FLAGS_RESET;
    cs = c86x_pkg::CS_RESET;
    ip = 16'h0000;
    mismatches = 0;
  endfunction

  function bit cond_holds(logic [3:0] cc);
    bit cf, zf, sf, of, pf, t;
    cf = flags[c86x_pkg::FLAG_CF];
    zf = flags[c86x_pkg::FLAG_ZF];
    sf = flags[c86x_pkg::FLAG_SF];
    of = flags[c86x_pkg::FLAG_OF];
    pf = flags[c86x_pkg::FLAG_PF];
    case (c86x_pkg::jcc_t'(cc[3:1]))
      c86x_pkg::JCC_O:  t = of;
      c86x_pkg::JCC_C:  t = cf;
      c86x_pkg::JCC_Z:  t = zf;
      c86x_pkg::JCC_BE: t = cf | zf;
      c86x_pkg::JCC_S:  t = sf;
      c86x_pkg::JCC_P:  t = pf;
      c86x_pkg::JCC_L:  t = sf ^ of;
      default: t = (sf ^ of) | zf;
    endcase
    return cc[0] ? !t : t;
  endfunction

  // runs one instruction on the shadow registers and queues what should retire
  function void note_request(logic [7:0] op, logic [15:0] opw, logic [15:0] segw);
    retire_rec_t r;
    logic [15:0] rel;
    logic [7:0]  ah;
    logic [1:0]  idx;
    r.len = c86x_pkg::LEN_ONE;
    r.unknown = 1'b0;
    if (op >= c86x_pkg::OP_JCC_LO && op <= c86x_pkg::OP_JCC_HI) begin
      rel = {{8{opw[7]}}, opw[7:0]};
      ip = ip + 16'd2;
      if (cond_holds(op[3:0])) ip = ip + rel;
      r.len = c86x_pkg::LEN_SHORT;
    end else if (op >= c86x_pkg::OP_MOV_R8_LO && op <= c86x_pkg::OP_MOV_R8_HI) begin
      idx = op[1:0];
      if (op[2]) gpr[idx][15:8] = opw[7:0];
      else gpr[idx][7:0] = opw[7:0];
      ip = ip + 16'd2;
      r.len = c86x_pkg::LEN_SHORT;
    end else begin
      ip = ip + 16'd1;
      case (op)
        c86x_pkg::OP_SAHF: flags = (flags & c86x_pkg::SAHF_KEEP_MASK)
          | {8'h00, gpr[c86x_pkg::GPR_AX][15:8] & c86x_pkg::SAHF_LOAD_MASK};
        c86x_pkg::OP_LAHF: begin
          ah = (gpr[c86x_pkg::GPR_AX][15:8] & c86x_pkg::LAHF_KEEP_MASK)
             | (flags[7:0] & c86x_pkg::LAHF_LOAD_MASK);
          gpr[c86x_pkg::GPR_AX][15:8] = ah;
        end
        c86x_pkg::OP_JMP_FAR: begin
          ip = opw;
          cs = segw;
          r.len = c86x_pkg::LEN_FAR;
        end
        c86x_pkg::OP_CLC: flags[c86x_pkg::FLAG_CF] = 1'b0;
        c86x_pkg::OP_STC: flags[c86x_pkg::FLAG_CF] = 1'b1;
        c86x_pkg::OP_CLI: flags[c86x_pkg::FLAG_IF] = 1'b0;
        c86x_pkg::OP_STI: flags[c86x_pkg::FLAG_IF] = 1'b1;
        c86x_pkg::OP_CLD: flags[c86x_pkg::FLAG_DF] = 1'b0;
        c86x_pkg::OP_STD: flags[c86x_pkg::FLAG_DF] = 1'b1;
        default: r.unknown = 1'b1;
      endcase
    end
    r.ip = ip;
    r.cs = cs;
    r.flags = flags;
    r.ax = gpr[c86x_pkg::GPR_AX];
    r.bx = gpr[c86x_pkg::GPR_BX];
    r.cx = gpr[c86x_pkg::GPR_CX];
    r.dx = gpr[c86x_pkg::GPR_DX];
    retire_q.push_back(r);
  endfunction

  function void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, exp_v, act_v);
    end
  endfunction

  function void check_retired(retire_rec_t act);
    retire_rec_t e;
    if (retire_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing pending (ip %h)", $realtime, act.ip);
      return;
    end
    e = retire_q.pop_front();
    check_field("next_ip", e.ip, act.ip);
    check_field("code_segment", e.cs, act.cs);
    check_field("flags_word", e.flags, act.flags);
    check_field("reg_ax", e.ax, act.ax);
    check_field("reg_bx", e.bx, act.bx);
    check_field("reg_cx", e.cx, act.cx);
    check_field("reg_dx", e.dx, act.dx);
    check_field("bytes_used", {13'd0, e.len}, {13'd0, act.len});
    check_field("unknown_opcode", {15'd0, e.unknown}, {15'd0, act.unknown});
  endfunction

  function int pending();
    return retire_q.size();
  endfunction
endclass

module cpu8086_subset_executor_test;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  cmd;
  logic [15:0] operand_word;
  logic [15:0] segment_word;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] next_ip;
  logic [15:0] code_segment;
  logic [15:0] flags_word;
  logic [15:0] reg_ax;
  logic [15:0] reg_bx;
  logic [15:0] reg_cx;
  logic [15:0] reg_dx;
  logic [2:0]  bytes_used;
  logic        unknown_opcode;

  exec_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned rx_cycle = 0;

  cpu8086_subset_executor DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .operand_word(operand_word),
    .segment_word(segment_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .next_ip(next_ip),
    .code_segment(code_segment),
    .flags_word(flags_word),
    .reg_ax(reg_ax),
    .reg_bx(reg_bx),
    .reg_cx(reg_cx),
    .reg_dx(reg_dx),
    .bytes_used(bytes_used),
    .unknown_opcode(unknown_opcode)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    retire_rec_t act;
    if (!rst) begin
      if (out_valid && out_ready) begin
        act.ip = next_ip;
        act.cs = code_segment;
        act.flags = flags_word;
        act.ax = reg_ax;
        act.bx = reg_bx;
        act.cx = reg_cx;
        act.dx = reg_dx;
        act.len = bytes_used;
        act.unknown = unknown_opcode;
        sb.check_retired(act);
      end
      if (in_valid && in_ready) sb.note_request(cmd, operand_word, segment_word);
    end
  end

  // result side stall pattern, cycling through four styles
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 97) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(1));
      2: out_ready <= (rx_cycle % 4) != 0;
      default: out_ready <= (rx_cycle % 16) < 4;
    endcase
  end

  task automatic send_request(input logic [7:0] op, input logic [15:0] opw,
                              input logic [15:0] segw);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(5) == 0) ? 120 : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    cmd <= op;
    operand_word <= opw;
    segment_word <= segw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic [7:0] pick_opcode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return 8'($urandom_range(c86x_pkg::OP_JCC_HI, c86x_pkg::OP_JCC_LO));
    if (r < 50) return c86x_pkg::OP_MOV_R8_LO + 8'($urandom_range(7));
    if (r < 58) return c86x_pkg::OP_SAHF;
    if (r < 63) return c86x_pkg::OP_LAHF;
    if (r < 78) return c86x_pkg::OP_CLC + 8'($urandom_range(5));
    if (r < 83) return c86x_pkg::OP_JMP_FAR;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int unsigned waited;
    logic [15:0] opw;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = 8'h00;
    operand_word = 16'h0000;
    segment_word = 16'h0000;
    out_ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // flag transfer through AH, then every flag op
    send_request(c86x_pkg::OP_LAHF, 16'hFFFF, 16'hFFFF);
    send_request(c86x_pkg::OP_MOV_R8_LO + 8'd4, 16'h00FF, 16'h0000);
    send_request(c86x_pkg::OP_SAHF, 16'h0000, 16'h0000);
    send_request(c86x_pkg::OP_LAHF, 16'h0000, 16'h0000);
    send_request(c86x_pkg::OP_CLC, 16'h0000, 16'h0000);
    send_request(c86x_pkg::OP_STC, 16'h0000, 16'h0000);
    send_request(c86x_pkg::OP_CLI, 16'h0000, 16'h0000);
    send_request(c86x_pkg::OP_STI, 16'h0000, 16'h0000);
    send_request(c86x_pkg::OP_STD, 16'h0000, 16'h0000);
    send_request(c86x_pkg::OP_CLD, 16'h0000, 16'h0000);
    // byte moves, high operand byte must be ignored
    send_request(c86x_pkg::OP_MOV_R8_LO + 8'd3, 16'h5580, 16'h0000);
    send_request(c86x_pkg::OP_MOV_R8_LO + 8'd7, 16'hAA7F, 16'hFFFF);
    send_request(c86x_pkg::OP_MOV_R8_LO + 8'd1, 16'hFF00, 16'h0000);
    send_request(c86x_pkg::OP_MOV_R8_LO + 8'd6, 16'h00A5, 16'h0000);
    // far jump to the top of the segment so the short jumps wrap
    send_request(c86x_pkg::OP_JMP_FAR, 16'hFFFF, 16'h0000);
    send_request(8'h74, 16'h0080, 16'h0000);
    send_request(8'h75, 16'hFF7F, 16'h0000);
    send_request(8'h6C, 16'h00FF, 16'h0000);
    send_request(8'h7F, 16'h0001, 16'h0000);
    send_request(8'h7A, 16'h0010, 16'h0000);
    send_request(8'h70, 16'h0080, 16'h0000);
    send_request(8'h00, 16'h0000, 16'h0000);
    send_request(8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(c86x_pkg::OP_JMP_FAR, 16'h0000, 16'hFFFF);

    for (int n = 0; n < 1400; n++) begin
      opw = 16'($urandom_range(16'hFFFF));
      send_request(pick_opcode(), opw, 16'($urandom_range(16'hFFFF)));
    end
    in_valid <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** cpu8086_subset_executor: PASSED **");
    end else begin
      $display("** cpu8086_subset_executor: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("** cpu8086_subset_executor: FAILED **");
    $finish;
  end

endmodule
